// File: hdl/bmmc_pkg.sv
package bmmc_pkg;

	// Field types of the event bundle and the status transaction.
	typedef logic [1:0] remote_t;
	typedef logic [1:0] timer_t;
	typedef logic [2:0] button_t;
	typedef logic [2:0] mode_t;
	typedef logic [1:0] heater_t;
	typedef logic [2:0] led_t;
	typedef logic [1:0] report_t;

	// Configuration port geometry.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from the word address bit.
	localparam logic REG_PUMP_DISABLE = 1'b0;

	// Appliance modes.
	localparam mode_t M_ERROR      = 3'd0;
	localparam mode_t M_OFF        = 3'd1;
	localparam mode_t M_SLEEP      = 3'd2;
	localparam mode_t M_HEAT_BREW  = 3'd3;
	localparam mode_t M_IDLE_BREW  = 3'd4;
	localparam mode_t M_HEAT_STEAM = 3'd5;
	localparam mode_t M_IDLE_STEAM = 3'd6;
	localparam mode_t M_COOLING    = 3'd7;

	// Heater targets.
	localparam heater_t H_OFF   = 2'd0;
	localparam heater_t H_BREW  = 2'd1;
	localparam heater_t H_STEAM = 2'd2;

	// Remote commands.
	localparam remote_t RC_NONE = 2'd0;
	localparam remote_t RC_ON   = 2'd1;
	localparam remote_t RC_OFF  = 2'd2;

	// Timer events.
	localparam timer_t TE_NONE = 2'd0;
	localparam timer_t TE_OFF  = 2'd1;
	localparam timer_t TE_ON   = 2'd2;

	// Button gestures.
	localparam button_t BTN_NONE  = 3'd0;
	localparam button_t BTN_CLICK = 3'd1;
	localparam button_t BTN_SHORT = 3'd2;
	localparam button_t BTN_LONG  = 3'd3;
	localparam button_t BTN_ERROR = 3'd4;

	// Report codes.
	localparam report_t PWR_NONE = 2'd0;
	localparam report_t PWR_OFF  = 2'd1;
	localparam report_t PWR_ON   = 2'd2;
	localparam report_t BRW_NONE    = 2'd0;
	localparam report_t BRW_STOPPED = 2'd1;
	localparam report_t BRW_STARTED = 2'd2;

	// LED pattern shown in each mode; sleep shows the half pattern.
	localparam led_t LED_OF_MODE [8] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

endpackage

// File: hdl/bmmc_if.sv
// Event bundle channel: one transaction per controller tick.
interface bmmc_in_if;
	logic                      valid;
	logic                      ready;
	bmmc_pkg::remote_t         remote_command;
	bmmc_pkg::timer_t          timer_event;
	logic                      brew_lever;
	bmmc_pkg::button_t         button_event;
	logic                      ready_at_brew;
	logic                      ready_at_steam;

	modport source (
		output valid, remote_command, timer_event, brew_lever, button_event,
			ready_at_brew, ready_at_steam,
		input  ready
	);
	modport sink (
		input  valid, remote_command, timer_event, brew_lever, button_event,
			ready_at_brew, ready_at_steam,
		output ready
	);
endinterface

// Status channel: one transaction per accepted event bundle.
interface bmmc_out_if;
	logic                      valid;
	logic                      ready;
	bmmc_pkg::mode_t           machine_mode;
	bmmc_pkg::heater_t         heater_target;
	logic                      pump_drive;
	bmmc_pkg::led_t            led_pattern;
	bmmc_pkg::report_t         power_report;
	bmmc_pkg::report_t         brew_report;

	modport source (
		output valid, machine_mode, heater_target, pump_drive, led_pattern,
			power_report, brew_report,
		input  ready
	);
	modport sink (
		input  valid, machine_mode, heater_target, pump_drive, led_pattern,
			power_report, brew_report,
		output ready
	);
endinterface

// File: hdl/boiler_machine_mode_controller_core.sv
// An accepted event bundle is held in the input register; its status transaction
// is held in the status register. Throughput: one event bundle per cycle while the
// status receiver does not stall; the mode update is combinational between them.
// Reset (arst_n low, asynchronous): mode off, heater off, pump and lever memory
// cleared, pump_disable cleared, both registers empty.
module boiler_machine_mode_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bmmc_in_if.sink                       tick,
	bmmc_out_if.source                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmmc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bmmc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bmmc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import bmmc_pkg::*;

	// Input register.
	logic    valid_s1;
	remote_t remote_s1;
	timer_t  timer_s1;
	logic    lever_s1;
	button_t button_s1;
	logic    rb_s1;
	logic    rs_s1;

	// Controller state.
	mode_t   mode_q;
	heater_t heater_q;
	logic    pump_q;
	logic    lever_mem_q;
	logic    pump_disable_q;

	// Status register.
	logic    out_valid_q;
	mode_t   out_mode_q;
	heater_t out_heater_q;
	logic    out_pump_q;
	led_t    out_led_q;
	report_t out_power_q;
	report_t out_brew_q;

	// Next-state values.
	mode_t   mode_d;
	heater_t heater_d;
	logic    pump_d;
	logic    lever_mem_d;
	report_t power_d;
	report_t brew_d;

	logic    advance;
	logic    cfg_write;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PUMP_DISABLE) begin
			prdata[0] = pump_disable_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_disable_q <= 1'b0;
		end else if (cfg_write && paddr[2] == REG_PUMP_DISABLE) begin
			pump_disable_q <= pwdata[0];
		end
	end

	// Handshake: the bundle in the input register moves on when the status
	// register is free or is being emptied in this cycle.
	assign advance     = valid_s1 && (!out_valid_q || status.ready);
	assign tick.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			remote_s1 <= tick.remote_command;
			timer_s1  <= tick.timer_event;
			lever_s1  <= tick.brew_lever;
			button_s1 <= tick.button_event;
			rb_s1     <= tick.ready_at_brew;
			rs_s1     <= tick.ready_at_steam;
		end
	end

	// Mode update: remote, timer, lever, button, then heater readiness.
	always_comb begin
		mode_d      = mode_q;
		heater_d    = heater_q;
		pump_d      = pump_q;
		lever_mem_d = lever_mem_q;
		power_d     = PWR_NONE;
		brew_d      = BRW_NONE;

		case (remote_s1)
			RC_ON: begin
				heater_d = H_BREW;
				mode_d   = M_HEAT_BREW;
			end
			RC_OFF: begin
				heater_d = H_OFF;
				mode_d   = M_OFF;
			end
			default: ;
		endcase

		case (timer_s1)
			TE_OFF: begin
				mode_d   = M_OFF;
				heater_d = H_OFF;
				power_d  = PWR_OFF;
			end
			TE_ON: begin
				if (mode_d inside {M_OFF, M_SLEEP}) begin
					mode_d   = M_HEAT_BREW;
					heater_d = H_BREW;
					power_d  = PWR_ON;
				end
			end
			default: ;
		endcase

		// The lever is not followed while the machine is off.
		if (mode_d != M_OFF && lever_mem_d != lever_s1) begin
			pump_d      = lever_s1;
			lever_mem_d = lever_s1;
			brew_d      = lever_s1 ? BRW_STARTED : BRW_STOPPED;
		end

		case (button_s1)
			BTN_NONE: ;
			BTN_CLICK: begin
				if (mode_d inside {M_OFF, M_SLEEP}) begin
					heater_d = H_BREW;
					mode_d   = M_HEAT_BREW;
					power_d  = PWR_ON;
				end else begin
					pump_d = !pump_d;
				end
			end
			BTN_SHORT: begin
				// A short press toggles between the brew and steam targets, selects brew from
				// off and is an error elsewhere; readiness is judged against the new target.
				if (mode_d == M_OFF) begin
					heater_d = H_BREW;
					mode_d   = M_HEAT_BREW;
				end else if (mode_d inside {M_HEAT_STEAM, M_IDLE_STEAM}) begin
					heater_d = H_BREW;
					mode_d   = rb_s1 ? M_IDLE_BREW : M_COOLING;
				end else if (mode_d inside {M_HEAT_BREW, M_IDLE_BREW, M_COOLING}) begin
					heater_d = H_STEAM;
					mode_d   = rs_s1 ? M_IDLE_STEAM : M_HEAT_STEAM;
				end else begin
					heater_d = H_OFF;
					mode_d   = M_ERROR;
				end
			end
			BTN_LONG: begin
				heater_d = H_OFF;
				pump_d   = 1'b0;
				mode_d   = M_OFF;
				power_d  = PWR_OFF;
			end
			default: begin
				heater_d = H_OFF;
				mode_d   = M_ERROR;
			end
		endcase

		// Heating finishes once the boiler reports the target temperature.
		if ((heater_d == H_BREW && rb_s1) || (heater_d == H_STEAM && rs_s1)) begin
			if (mode_d inside {M_COOLING, M_HEAT_BREW}) begin
				mode_d = M_IDLE_BREW;
			end else if (mode_d == M_HEAT_STEAM) begin
				mode_d = M_IDLE_STEAM;
			end
		end
	end

	// State registers follow each bundle as it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_OFF;
			heater_q    <= H_OFF;
			pump_q      <= 1'b0;
			lever_mem_q <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_d;
			heater_q    <= heater_d;
			pump_q      <= pump_d;
			lever_mem_q <= lever_mem_d;
		end
	end

	// Status register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_mode_q   <= mode_d;
			out_heater_q <= heater_d;
			out_pump_q   <= pump_d && !pump_disable_q;
			out_led_q    <= LED_OF_MODE[mode_d];
			out_power_q  <= power_d;
			out_brew_q   <= brew_d;
		end
	end

	assign status.valid         = out_valid_q;
	assign status.machine_mode  = out_mode_q;
	assign status.heater_target = out_heater_q;
	assign status.pump_drive    = out_pump_q;
	assign status.led_pattern   = out_led_q;
	assign status.power_report  = out_power_q;
	assign status.brew_report   = out_brew_q;

`ifndef SYNTH
	// The heater is off whenever the machine is off or in error.
	a_heater_off_when_down: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_OFF || mode_q == M_ERROR) |-> heater_q == H_OFF)
		else $error("heater on while machine is off or in error");

	// Brew-side modes keep the heater at brew temperature.
	a_brew_modes_heater: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HEAT_BREW || mode_q == M_IDLE_BREW || mode_q == M_COOLING)
		|-> heater_q == H_BREW)
		else $error("brew mode without brew heater target");

	// Steam-side modes keep the heater at steam temperature.
	a_steam_modes_heater: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HEAT_STEAM || mode_q == M_IDLE_STEAM) |-> heater_q == H_STEAM)
		else $error("steam mode without steam heater target");

	// A status transaction only appears after a bundle was in the input register.
	a_status_from_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("status transaction without a processed bundle");
`endif

endmodule

// File: tb/tb_boiler_machine_mode_controller_core.sv
`timescale 1ns / 1ps

module tb_boiler_machine_mode_controller_core;
	import bmmc_pkg::*;

	// Codes outside the defined sets; the block must tolerate them.
	localparam remote_t RC_RESERVED     = 2'd3;
	localparam timer_t  TE_RESERVED     = 2'd3;
	localparam button_t BTN_RESERVED_LO = 3'd5;
	localparam button_t BTN_RESERVED_HI = 3'd7;

	// Byte address of the pump disable register.
	localparam logic [PADDR_W-1:0] PUMP_DISABLE_ADDR = {REG_PUMP_DISABLE, 2'b00};

	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		remote_t remote;
		timer_t  timer;
		logic    lever;
		button_t button;
		logic    rdy_brew;
		logic    rdy_steam;
	} tick_bundle_t;

	typedef struct packed {
		mode_t   mode;
		heater_t heater;
		logic    pump;
		led_t    led;
		report_t power;
		report_t brew;
	} status_word_t;

	// Tracks the appliance mode machine and holds the status words still owed.
	class mode_scoreboard;
		mode_t   mode;
		heater_t heater;
		logic    pump_on;
		logic    lever_mem;
		logic    pump_disable;
		int      fail_count;
		status_word_t pending_status[$];

		function new();
			mode         = M_OFF;
			heater       = H_OFF;
			pump_on      = 1'b0;
			lever_mem    = 1'b0;
			pump_disable = 1'b0;
			fail_count   = 0;
		endfunction

		function bit boiler_ready(logic rb, logic rs);
			if (heater == H_BREW) return rb;
			if (heater == H_STEAM) return rs;
			return 1'b0;
		endfunction

		// Applies one bundle in the fixed order and queues the expected status.
		function void take_event(tick_bundle_t b);
			status_word_t s;
			report_t pwr;
			report_t brw;
			pwr = PWR_NONE;
			brw = BRW_NONE;

			if (b.remote == RC_ON) begin
				heater = H_BREW;
				mode = M_HEAT_BREW;
			end else if (b.remote == RC_OFF) begin
				heater = H_OFF;
				mode = M_OFF;
			end

			if (b.timer == TE_OFF) begin
				mode = M_OFF;
				heater = H_OFF;
				pwr = PWR_OFF;
			end else if (b.timer == TE_ON && (mode == M_OFF || mode == M_SLEEP)) begin
				mode = M_HEAT_BREW;
				heater = H_BREW;
				pwr = PWR_ON;
			end

			// The lever is not seen while the machine is off.
			if (mode != M_OFF && lever_mem != b.lever) begin
				pump_on = b.lever;
				lever_mem = b.lever;
				brw = b.lever ? BRW_STARTED : BRW_STOPPED;
			end

			case (b.button)
				BTN_NONE: ;
				BTN_CLICK: begin
					if (mode == M_OFF || mode == M_SLEEP) begin
						heater = H_BREW;
						mode = M_HEAT_BREW;
						pwr = PWR_ON;
					end else begin
						pump_on = ~pump_on;
					end
				end
				BTN_SHORT: begin
					if (mode == M_OFF) begin
						heater = H_BREW;
						mode = M_HEAT_BREW;
					end else if (mode == M_HEAT_STEAM || mode == M_IDLE_STEAM) begin
						heater = H_BREW;
						mode = boiler_ready(b.rdy_brew, b.rdy_steam) ? M_IDLE_BREW : M_COOLING;
					end else if (mode == M_HEAT_BREW || mode == M_IDLE_BREW ||
							mode == M_COOLING) begin
						heater = H_STEAM;
						mode = boiler_ready(b.rdy_brew, b.rdy_steam) ? M_IDLE_STEAM
							: M_HEAT_STEAM;
					end else begin
						heater = H_OFF;
						mode = M_ERROR;
					end
				end
				BTN_LONG: begin
					heater = H_OFF;
					pump_on = 1'b0;
					mode = M_OFF;
					pwr = PWR_OFF;
				end
				default: begin
					heater = H_OFF;
					mode = M_ERROR;
				end
			endcase

			if (boiler_ready(b.rdy_brew, b.rdy_steam)) begin
				if (mode == M_COOLING || mode == M_HEAT_BREW) mode = M_IDLE_BREW;
				else if (mode == M_HEAT_STEAM) mode = M_IDLE_STEAM;
			end

			s.mode   = mode;
			s.heater = heater;
			s.pump   = pump_on & ~pump_disable;
			// Patterns follow the mode codes shifted down by one; error wraps to gallop.
			s.led    = led_t'(mode - 3'd1);
			s.power  = pwr;
			s.brew   = brw;
			pending_status.push_back(s);
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
				fail_count++;
			end
		endfunction

		function void check_status(status_word_t act);
			status_word_t exp;
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected status transaction, expected none, actual %h",
					$time, act);
				fail_count++;
				return;
			end
			exp = pending_status.pop_front();
			compare_field("machine_mode", 32'(exp.mode), 32'(act.mode));
			compare_field("heater_target", 32'(exp.heater), 32'(act.heater));
			compare_field("pump_drive", 32'(exp.pump), 32'(act.pump));
			compare_field("led_pattern", 32'(exp.led), 32'(act.led));
			compare_field("power_report", 32'(exp.power), 32'(act.power));
			compare_field("brew_report", 32'(exp.brew), 32'(act.brew));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bmmc_in_if  tick_bus();
	bmmc_out_if status_bus();

	mode_scoreboard sb = new();
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic rand_lever;

	boiler_machine_mode_controller_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_bus),
		.status  (status_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#500000;
		$display("Verification failed");
		$finish;
	end

	// Receiver stalls at random according to the current phase.
	always @(negedge clk) begin
		status_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watches both channels at the rising edge.
	always @(posedge clk) begin
		tick_bundle_t b;
		status_word_t s;
		if (arst_n) begin
			if (tick_bus.valid && tick_bus.ready) begin
				b.remote    = tick_bus.remote_command;
				b.timer     = tick_bus.timer_event;
				b.lever     = tick_bus.brew_lever;
				b.button    = tick_bus.button_event;
				b.rdy_brew  = tick_bus.ready_at_brew;
				b.rdy_steam = tick_bus.ready_at_steam;
				sb.take_event(b);
			end
			if (status_bus.valid && status_bus.ready) begin
				s.mode   = status_bus.machine_mode;
				s.heater = status_bus.heater_target;
				s.pump   = status_bus.pump_drive;
				s.led    = status_bus.led_pattern;
				s.power  = status_bus.power_report;
				s.brew   = status_bus.brew_report;
				sb.check_status(s);
			end
		end
	end

	// Presents one bundle, after random idle cycles, and waits until it is accepted.
	task automatic send_event(input tick_bundle_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(negedge clk);
		end
		tick_bus.valid          <= 1'b1;
		tick_bus.remote_command <= b.remote;
		tick_bus.timer_event    <= b.timer;
		tick_bus.brew_lever     <= b.lever;
		tick_bus.button_event   <= b.button;
		tick_bus.ready_at_brew  <= b.rdy_brew;
		tick_bus.ready_at_steam <= b.rdy_steam;
		@(posedge clk);
		while (!tick_bus.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send(input remote_t r, input timer_t t, input logic lv, input button_t bt,
			input logic rb, input logic rs);
		send_event('{r, t, lv, bt, rb, rs});
	endtask

	// Lowers valid and waits until every status word owed has arrived.
	task automatic drain_status();
		tick_bus.valid <= 1'b0;
		while (sb.pending_status.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the pump disable register and reads it back.
	task automatic set_pump_disable(input logic value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PUMP_DISABLE_ADDR;
		pwdata  <= {{(PDATA_W-1){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.pump_disable = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[0] !== value) begin
			$display("%0t: pump_disable readback mismatch, expected %0d, actual %0d",
				$time, value, prdata[0]);
			sb.fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random bundle weighted toward commands that keep the machine busy.
	function automatic tick_bundle_t random_bundle();
		tick_bundle_t b;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 72) b.remote = RC_NONE;
		else if (p < 84) b.remote = RC_ON;
		else if (p < 93) b.remote = RC_OFF;
		else b.remote = RC_RESERVED;
		p = $urandom_range(99);
		if (p < 80) b.timer = TE_NONE;
		else if (p < 86) b.timer = TE_OFF;
		else if (p < 95) b.timer = TE_ON;
		else b.timer = TE_RESERVED;
		// The lever is held for a while between changes.
		if ($urandom_range(99) < 25) rand_lever = ~rand_lever;
		b.lever = rand_lever;
		p = $urandom_range(99);
		if (p < 38) b.button = BTN_NONE;
		else if (p < 55) b.button = BTN_CLICK;
		else if (p < 78) b.button = BTN_SHORT;
		else if (p < 86) b.button = BTN_LONG;
		else if (p < 92) b.button = BTN_ERROR;
		else b.button = button_t'($urandom_range(BTN_RESERVED_HI, BTN_RESERVED_LO));
		b.rdy_brew  = 1'($urandom_range(1));
		b.rdy_steam = 1'($urandom_range(1));
		return b;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) send_event(random_bundle());
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.remote_command = RC_NONE;
		tick_bus.timer_event = TE_NONE;
		tick_bus.brew_lever = 1'b0;
		tick_bus.button_event = BTN_NONE;
		tick_bus.ready_at_brew = 1'b0;
		tick_bus.ready_at_steam = 1'b0;
		rand_lever = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 81;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_pump_disable(1'b0);

		// Directed part: mode walk, reports, reserved codes and colliding events.
		send(RC_NONE, TE_NONE, 1'b1, BTN_NONE, 1'b0, 1'b0);
		send(RC_ON, TE_NONE, 1'b1, BTN_NONE, 1'b0, 1'b0);
		send(RC_NONE, TE_NONE, 1'b1, BTN_NONE, 1'b1, 1'b0);
		send(RC_NONE, TE_NONE, 1'b0, BTN_CLICK, 1'b1, 1'b0);
		send(RC_NONE, TE_NONE, 1'b0, BTN_SHORT, 1'b0, 1'b1);
		send(RC_NONE, TE_NONE, 1'b0, BTN_SHORT, 1'b0, 1'b1);
		send(RC_NONE, TE_NONE, 1'b0, BTN_NONE, 1'b1, 1'b0);
		send(RC_NONE, TE_NONE, 1'b1, BTN_SHORT, 1'b1, 1'b0);
		send(RC_NONE, TE_NONE, 1'b1, BTN_LONG, 1'b1, 1'b1);
		send(RC_NONE, TE_ON, 1'b1, BTN_NONE, 1'b0, 1'b0);
		send(RC_NONE, TE_ON, 1'b0, BTN_NONE, 1'b0, 1'b0);
		send(RC_NONE, TE_NONE, 1'b0, BTN_ERROR, 1'b1, 1'b1);
		send(RC_NONE, TE_NONE, 1'b0, BTN_SHORT, 1'b1, 1'b1);
		send(RC_NONE, TE_NONE, 1'b1, BTN_CLICK, 1'b0, 1'b0);
		send(RC_NONE, TE_NONE, 1'b1, BTN_RESERVED_HI, 1'b0, 1'b0);
		send(RC_RESERVED, TE_RESERVED, 1'b1, BTN_RESERVED_LO, 1'b1, 1'b1);
		send(RC_OFF, TE_NONE, 1'b0, BTN_NONE, 1'b0, 1'b0);
		send(RC_NONE, TE_OFF, 1'b0, BTN_CLICK, 1'b0, 1'b0);
		send(RC_ON, TE_OFF, 1'b1, BTN_NONE, 1'b1, 1'b1);
		send(RC_NONE, TE_NONE, 1'b1, BTN_CLICK, 1'b1, 1'b1);
		send(RC_RESERVED, TE_RESERVED, 1'b1, BTN_RESERVED_HI, 1'b1, 1'b1);
		send(RC_OFF, TE_ON, 1'b0, BTN_LONG, 1'b1, 1'b1);
		drain_status();

		// Random phase one: the receiver stalls more than the sender idles.
		set_pump_disable(1'b1);
		send_random(PHASE_ITEMS);
		drain_status();

		// Random phase two: the other way round.
		send_idle_pct = 81;
		recv_idle_pct = 35;
		set_pump_disable(1'b0);
		send_random(PHASE_ITEMS);
		drain_status();

		// Random phase three: no idling, with one pause until all status has come.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_pump_disable(1'b1);
		send_random(PHASE_ITEMS / 2);
		drain_status();
		send_random(PHASE_ITEMS / 2);
		drain_status();
		repeat (8) @(negedge clk);

		if (sb.fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/bmmc_pkg.sv
hdl/bmmc_if.sv
hdl/boiler_machine_mode_controller_core.sv
tb/tb_boiler_machine_mode_controller_core.sv
